>>> design/text_mode_terminal_writer_unit_assert.svh
// ---------------------------------------------------------------------------
// Text mode terminal writer: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and idle during reset.
// ---------------------------------------------------------------------------
`ifndef TEXT_MODE_TERMINAL_WRITER_UNIT_ASSERT_SVH
`define TEXT_MODE_TERMINAL_WRITER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ttw_pkg.sv
// ---------------------------------------------------------------------------
// Text mode terminal writer: package
// Field widths, action and character codes, register indices and shared types.
// ---------------------------------------------------------------------------
package ttw_pkg;

    localparam int ACT_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int COLOR_W    = 8;
    localparam int CELL_W     = 16;
    localparam int POS_W      = 11;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCROLL,
        ST_CLEAR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0]     pos;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic [CELL_W-1:0]    data;
    } t_result;

endpackage

>>> design/ttw_screen_ram.sv
// ---------------------------------------------------------------------------
// Text mode terminal writer: screen memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ttw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/ttw_seq.sv
// ---------------------------------------------------------------------------
// Text mode terminal writer: sequencer
// Holds the cursor, decodes each item and drives the screen memory, including
// the scroll copy and the clear fill sweeps.
// ---------------------------------------------------------------------------
`include "text_mode_terminal_writer_unit_assert.svh"

module ttw_seq
    import ttw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ACT_W-1:0]    i_action,
    input  logic [CHAR_W-1:0]   i_char_code,
    input  logic [IDX_W-1:0]    i_cell_index,
    input  logic [COLOR_W-1:0]  i_text_color,
    input  logic [COLOR_W-1:0]  i_fill_color,
    output logic                o_done,
    input  logic                i_done_take,
    output t_result             o_result
);

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int ROW_W      = $clog2(SCREEN_HEIGHT);
    localparam int COL_W      = $clog2(SCREEN_WIDTH);

    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_rd_hit, n_rd_hit;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    logic               accept;
    logic               is_newline;
    logic               is_backspace;
    logic               last_row;
    logic               last_col;
    logic               idx_in_range;
    logic               wraps_down;
    logic [AW-1:0]      cur_lin;

    assign accept       = i_in_valid && (r_state == ST_IDLE);
    assign is_newline   = (i_char_code == CH_NEWLINE);
    assign is_backspace = (i_char_code == CH_BACKSPACE);
    assign last_row     = (r_row == ROW_W'(SCREEN_HEIGHT - 1));
    assign last_col     = (r_col == COL_W'(SCREEN_WIDTH - 1));
    assign idx_in_range = (32'(i_cell_index) < 32'(CELL_COUNT));
    assign cur_lin      = AW'(r_row * SCREEN_WIDTH) + AW'(r_col);

    // A put that leaves the last row starts a scroll.
    assign wraps_down = (i_action == ACT_PUT) && last_row &&
                        (is_newline || (!is_backspace && last_col));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if (wraps_down) begin
                        n_state = ST_SCROLL;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCROLL: begin
                if (r_cnt == CNT_W'(CELL_COUNT)) begin
                    n_state = ST_DONE;
                end
            end
            ST_CLEAR: begin
                if (r_cnt == CNT_W'(CELL_COUNT - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_done_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_cnt    = r_cnt + CNT_W'(1);
        n_rd_hit = r_rd_hit;
        if (accept) begin
            n_cnt    = '0;
            n_rd_hit = (i_action == ACT_READ) && idx_in_range;
            case (i_action)
                ACT_PUT: begin
                    if (is_newline || (!is_backspace && last_col)) begin
                        n_col = '0;
                        if (!last_row) begin
                            n_row = r_row + ROW_W'(1);
                        end
                    end else if (is_backspace) begin
                        if (r_col != '0) begin
                            n_col = r_col - COL_W'(1);
                        end
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
                ACT_CLEAR: begin
                    n_row = '0;
                    n_col = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_lin;
        ram_wdata = {i_text_color, i_char_code};
        ram_re    = 1'b0;
        ram_raddr = AW'(i_cell_index);
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_action == ACT_PUT)) begin
                    if (is_backspace) begin
                        ram_we    = (r_col != '0);
                        ram_waddr = cur_lin - AW'(1);
                        ram_wdata = {i_text_color, CH_BLANK};
                    end else begin
                        ram_we = !is_newline;
                    end
                end
                ram_re = accept && (i_action == ACT_READ) && idx_in_range;
            end
            ST_SCROLL: begin
                ram_re    = (r_cnt < CNT_W'(CELL_COUNT - SCREEN_WIDTH));
                ram_raddr = AW'(r_cnt + CNT_W'(SCREEN_WIDTH));
                ram_we    = (r_cnt != '0);
                ram_waddr = AW'(r_cnt - CNT_W'(1));
                if (r_cnt < CNT_W'(CELL_COUNT - SCREEN_WIDTH + 1)) begin
                    ram_wdata = ram_rdata;
                end else begin
                    ram_wdata = {i_fill_color, CH_BLANK};
                end
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_cnt);
                ram_wdata = {i_text_color, CH_BLANK};
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_row    <= '0;
            r_col    <= '0;
            r_cnt    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_cnt    <= n_cnt;
            r_rd_hit <= n_rd_hit;
        end
    end

    ttw_screen_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW),
        .DW    (CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_done        = (r_state == ST_DONE);
    assign o_result.pos  = POS_W'(cur_lin);
    assign o_result.row  = ROW_OUT_W'(r_row);
    assign o_result.col  = COL_OUT_W'(r_col);
    assign o_result.data = r_rd_hit ? ram_rdata : '0;

    `TTW_ASSERT_NEXT(a_clear_homes, accept && (i_action == ACT_CLEAR),
        (r_state == ST_CLEAR) && (r_row == '0) && (r_col == '0),
        "Clear did not home the cursor and start the fill sweep.")
    `TTW_ASSERT_NOW(a_scroll_cursor, r_state == ST_SCROLL,
        last_row && (r_col == '0),
        "Cursor is not at the start of the last row during a scroll.")
    `TTW_ASSERT_NEXT(a_put_advance,
        accept && (i_action == ACT_PUT) && !is_newline && !is_backspace && !last_col,
        (r_col == $past(r_col) + COL_W'(1)) && (r_row == $past(r_row)),
        "Printed character did not advance the cursor by one column.")
    `TTW_ASSERT_NEXT(a_done_hold, (r_state == ST_DONE) && !i_done_take,
        (r_state == ST_DONE) && $stable(r_row) && $stable(r_col),
        "Result changed before its transfer.")

endmodule

>>> design/text_mode_terminal_writer_unit.sv
// A put, read or unused action goes from the sequencer's done state to the output result register.
// A put that scrolls first runs the memory copy sweep, moving the rows up and blanking the last row.
// A clear first runs the fill sweep, one screen memory write per cell.
// The sequencer idles, and takes a new item, only once its result has moved on.
// Reset homes the cursor and sets both colours to 10; the screen memory holds no value until cleared.
// ---------------------------------------------------------------------------
// Text mode terminal writer: top level
// Configuration registers, input handshake and the output result register.
// ---------------------------------------------------------------------------
module text_mode_terminal_writer_unit
    import ttw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic [IDX_W-1:0]      i_cell_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [POS_W-1:0]      o_cursor_position,
    output logic [ROW_OUT_W-1:0]  o_cursor_row,
    output logic [COL_OUT_W-1:0]  o_cursor_column,
    output logic [CELL_W-1:0]     o_cell_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COLOR_W-1:0]    i_cfg_data
);

    logic [COLOR_W-1:0] r_text_color;
    logic [COLOR_W-1:0] r_fill_color;
    logic               r_out_valid;
    t_result            r_out;

    logic               seq_ready;
    logic               seq_done;
    logic               done_take;
    t_result            seq_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= COLOR_W'(10);
            r_fill_color <= COLOR_W'(10);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TEXT_COLOR: r_text_color <= i_cfg_data;
                REG_FILL_COLOR: r_fill_color <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ttw_seq #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (seq_ready),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_text_color (r_text_color),
        .i_fill_color (r_fill_color),
        .o_done       (seq_done),
        .i_done_take  (done_take),
        .o_result     (seq_result)
    );

    assign done_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_take) begin
            r_out_valid <= seq_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done && done_take) begin
            r_out <= seq_result;
        end
    end

    assign o_in_stall        = !seq_ready;
    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_out.pos;
    assign o_cursor_row      = r_out.row;
    assign o_cursor_column   = r_out.col;
    assign o_cell_data       = r_out.data;

endmodule
